[rtl/blpg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blpg_pkg
// Shared types and constants for the line pixel generator.
// ----------------------------------------------------------------------------
package blpg_pkg;

   // screen size register width
   localparam int SCREEN_BITS = 13;
   // frame-buffer address width
   localparam int ADDR_BITS   = 24;
   // csr bus widths
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // csr word addresses (decoded on paddr[2])
   localparam logic CSR_SEL_WIDTH  = 1'b0;
   localparam logic CSR_SEL_HEIGHT = 1'b1;

   // reset values of the screen size
   localparam logic [SCREEN_BITS-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = 13'd480;

   // item codes
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_STEP = 1'b1;

   // screen configuration
   typedef struct packed {
      logic [SCREEN_BITS-1:0] width;
      logic [SCREEN_BITS-1:0] height;
   } screen_cfg_type;

   // walker status toward the output stage
   typedef struct packed {
      logic emit;     // this beat produces a pixel
      logic last;     // pixel is the end point
      logic active;   // a line is in progress
   } walk_status_type;

endpackage : blpg_pkg
`default_nettype wire

[rtl/blpg_channels.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blpg channels
// Valid/ready channel interfaces for line commands and emitted pixels.
// ----------------------------------------------------------------------------
interface blpg_req_if #(
   parameter int COORD_BITS = 13
) ();
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   logic [31:0]                  line_color;

   modport source (output valid, mode, start_x, start_y, end_x, end_y, line_color,
                   input ready);
   modport sink   (input valid, mode, start_x, start_y, end_x, end_y, line_color,
                   output ready);
endinterface : blpg_req_if

interface blpg_rsp_if #(
   parameter int COORD_BITS = 13
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic [31:0]                  pixel_color;
   logic                         visible;
   logic [23:0]                  fb_address;
   logic                         last;

   modport source (output valid, pixel_x, pixel_y, pixel_color, visible, fb_address,
                   last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, visible, fb_address,
                   last, output ready);
endinterface : blpg_rsp_if
`default_nettype wire

[rtl/blpg_csr.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blpg_csr
// APB-style register file holding the screen width and height.
// ----------------------------------------------------------------------------
module blpg_csr
   import blpg_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready,
   output screen_cfg_type                cfg
);

   screen_cfg_type cfg_ff, cfg_in;
   logic           wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[2])
            CSR_SEL_WIDTH:  cfg_in.width  = pwdata[SCREEN_BITS-1:0];
            CSR_SEL_HEIGHT: cfg_in.height = pwdata[SCREEN_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= WIDTH_RESET;
         cfg_ff.height <= HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (paddr[2])
         CSR_SEL_WIDTH:  prdata = CSR_DATA_BITS'(cfg_ff.width);
         CSR_SEL_HEIGHT: prdata = CSR_DATA_BITS'(cfg_ff.height);
         default:        prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule : blpg_csr
`default_nettype wire

[rtl/blpg_walker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blpg_walker
// Line state and Bresenham error-term stepping, one beat per cycle in which take is high.
// ----------------------------------------------------------------------------
module blpg_walker
   import blpg_pkg::*;
#(
   parameter int COORD_BITS = 13
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         take,
   input  wire logic                         mode,
   input  wire logic signed [COORD_BITS-1:0] start_x,
   input  wire logic signed [COORD_BITS-1:0] start_y,
   input  wire logic signed [COORD_BITS-1:0] end_x,
   input  wire logic signed [COORD_BITS-1:0] end_y,
   input  wire logic        [31:0]           line_color,
   output logic      signed [COORD_BITS-1:0] cur_x,
   output logic      signed [COORD_BITS-1:0] cur_y,
   output logic             [31:0]           cur_color,
   output walk_status_type                   status
);

   localparam int DW = COORD_BITS + 1;   // span width / signed difference
   localparam int EW = COORD_BITS + 2;   // error term width
   localparam int XW = COORD_BITS + 3;   // doubled error width

   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_BITS-1:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic        [DW-1:0]         dx_ff, dx_in, dy_ff, dy_in;
   logic                         neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic signed [EW-1:0]         err_ff, err_in;
   logic        [31:0]           color_ff, color_in;
   logic                         active_ff, active_in;

   logic signed [DW-1:0] diff_x, diff_y;
   logic        [DW-1:0] span_x, span_y;
   logic signed [XW-1:0] e2, dxs, dys, err_wide;
   logic                 at_end, move_x, move_y;

   // spans of a new line
   assign diff_x = $signed({end_x[COORD_BITS-1], end_x}) -
                   $signed({start_x[COORD_BITS-1], start_x});
   assign diff_y = $signed({end_y[COORD_BITS-1], end_y}) -
                   $signed({start_y[COORD_BITS-1], start_y});
   assign span_x = diff_x[DW-1] ? DW'(-diff_x) : diff_x;
   assign span_y = diff_y[DW-1] ? DW'(-diff_y) : diff_y;

   // error-term decisions
   assign at_end   = (cur_x_ff == tgt_x_ff) && (cur_y_ff == tgt_y_ff);
   assign e2       = $signed({err_ff, 1'b0});
   assign dxs      = $signed(XW'(dx_ff));
   assign dys      = $signed(XW'(dy_ff));
   assign move_x   = e2 > -dys;
   assign move_y   = e2 < dxs;
   assign err_wide = $signed({err_ff[EW-1], err_ff}) - (move_x ? dys : '0)
                     + (move_y ? dxs : '0);

   // next state
   always_comb begin
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      tgt_x_in  = tgt_x_ff;
      tgt_y_in  = tgt_y_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      neg_x_in  = neg_x_ff;
      neg_y_in  = neg_y_ff;
      err_in    = err_ff;
      color_in  = color_ff;
      active_in = active_ff;
      if (take) begin
         if (mode == MODE_LOAD) begin
            cur_x_in  = start_x;
            cur_y_in  = start_y;
            tgt_x_in  = end_x;
            tgt_y_in  = end_y;
            dx_in     = span_x;
            dy_in     = span_y;
            neg_x_in  = !(diff_x > 0);
            neg_y_in  = !(diff_y > 0);
            err_in    = $signed(EW'(span_x)) - $signed(EW'(span_y));
            color_in  = line_color;
            active_in = 1'b1;
         end else if (active_ff) begin
            if (at_end) begin
               active_in = 1'b0;
            end else begin
               err_in = err_wide[EW-1:0];
               if (move_x) begin
                  cur_x_in = neg_x_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
               end
               if (move_y) begin
                  cur_y_in = neg_y_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
               end
            end
         end
      end
   end

   // line state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      tgt_x_ff <= tgt_x_in;
      tgt_y_ff <= tgt_y_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      neg_x_ff <= neg_x_in;
      neg_y_ff <= neg_y_in;
      err_ff   <= err_in;
      color_ff <= color_in;
   end

   assign cur_x         = cur_x_ff;
   assign cur_y         = cur_y_ff;
   assign cur_color     = color_ff;
   assign status.emit   = take && (mode == MODE_STEP) && active_ff;
   assign status.last   = at_end;
   assign status.active = active_ff;

endmodule : blpg_walker
`default_nettype wire

[rtl/blpg_raster.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blpg_raster
// Screen clipping, frame-buffer address and the pixel output register.
// ----------------------------------------------------------------------------
module blpg_raster
   import blpg_pkg::*;
#(
   parameter int COORD_BITS = 13
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire screen_cfg_type               cfg,
   input  wire walk_status_type              status,
   input  wire logic signed [COORD_BITS-1:0] cur_x,
   input  wire logic signed [COORD_BITS-1:0] cur_y,
   input  wire logic        [31:0]           cur_color,
   output logic                              open,
   blpg_rsp_if.source                        rsp_bus
);

   localparam int UW = COORD_BITS - 1;                       // magnitude bits
   localparam int CW = (UW > SCREEN_BITS ? UW : SCREEN_BITS) + 1;
   localparam int PW = UW + SCREEN_BITS;                     // product width

   logic                         valid_ff, valid_in;
   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic        [31:0]           color_ff;
   logic                         vis_ff, last_ff;
   logic        [ADDR_BITS-1:0]  addr_ff;

   logic [UW-1:0]        x_mag, y_mag;
   logic                 in_x, in_y, vis;
   logic [PW-1:0]        row_base;
   logic [ADDR_BITS-1:0] addr;

   // clip against the screen
   assign x_mag = cur_x[UW-1:0];
   assign y_mag = cur_y[UW-1:0];
   assign in_x  = !cur_x[COORD_BITS-1] && (CW'(x_mag) < CW'(cfg.width));
   assign in_y  = !cur_y[COORD_BITS-1] && (CW'(y_mag) < CW'(cfg.height));
   assign vis   = in_x && in_y;

   // row stride times y plus x, modulo the address width
   assign row_base = PW'(y_mag) * PW'(cfg.width);
   assign addr     = vis ? (ADDR_BITS'(row_base) + ADDR_BITS'(x_mag)) : '0;

   // output register takes a new beat when empty or being drained
   assign open     = !valid_ff || rsp_bus.ready;
   assign valid_in = status.emit || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (status.emit) begin
         px_ff    <= cur_x;
         py_ff    <= cur_y;
         color_ff <= cur_color;
         vis_ff   <= vis;
         addr_ff  <= addr;
         last_ff  <= status.last;
      end
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.pixel_x     = px_ff;
   assign rsp_bus.pixel_y     = py_ff;
   assign rsp_bus.pixel_color = color_ff;
   assign rsp_bus.visible     = vis_ff;
   assign rsp_bus.fb_address  = addr_ff;
   assign rsp_bus.last        = last_ff;

endmodule : blpg_raster
`default_nettype wire

[rtl/bresenham_line_pixel_generator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator
// Integer line walker emitting clipped pixels with frame-buffer addresses.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake         | beat
//  req_bus  | in  | valid/ready       | mode, endpoints, line_color
//  rsp_bus  | out | valid/ready       | pixel x/y, color, visible, fb_address, last
//  apb      | in  | psel/penable      | screen_width @0x0, screen_height @0x4
//
//  One beat per cycle while req_bus.ready is high: a step beat's pixel appears
//  in the output register on the next cycle, with its clip flag and y*width address.
//  Reset empties the output register and leaves the walker idle; the screen
//  size returns to 640x480.
//  req_bus.ready drops only while a pixel sits in the output register and
//  rsp_bus.ready is low.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator
   import blpg_pkg::*;
#(
   parameter int COORD_BITS = 13
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   blpg_req_if.sink                      req_bus,
   blpg_rsp_if.source                    rsp_bus,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready
);

   screen_cfg_type               cfg;
   walk_status_type              status;
   logic signed [COORD_BITS-1:0] cur_x, cur_y;
   logic        [31:0]           cur_color;
   logic                         open, take;

   assign req_bus.ready = open;
   assign take          = req_bus.valid && open;

   // screen size registers
   blpg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // line state and stepping
   blpg_walker #(.COORD_BITS(COORD_BITS)) u_walker (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .mode       (req_bus.mode),
      .start_x    (req_bus.start_x),
      .start_y    (req_bus.start_y),
      .end_x      (req_bus.end_x),
      .end_y      (req_bus.end_y),
      .line_color (req_bus.line_color),
      .cur_x      (cur_x),
      .cur_y      (cur_y),
      .cur_color  (cur_color),
      .status     (status)
   );

   // clipping, address and output register
   blpg_raster #(.COORD_BITS(COORD_BITS)) u_raster (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .status    (status),
      .cur_x     (cur_x),
      .cur_y     (cur_y),
      .cur_color (cur_color),
      .open      (open),
      .rsp_bus   (rsp_bus)
   );

`ifndef SYNTHESIS
   // a step on an active line always lands in the output register
   a_step_emits: assert property (@(posedge clock) disable iff (reset)
      (take && req_bus.mode == MODE_STEP && status.active) |=> rsp_bus.valid)
      else $error("step beat on active line produced no pixel");

   // a load into an empty output register produces no pixel
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (take && req_bus.mode == MODE_LOAD && !rsp_bus.valid) |=> !rsp_bus.valid)
      else $error("load beat produced a pixel");

   // emitting the end point leaves the walker idle
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      (status.emit && status.last) |=> !status.active)
      else $error("walker still active after end point");

   // output register is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("pixel valid right after reset");
`endif

endmodule : bresenham_line_pixel_generator
`default_nettype wire
